// File: rtl/srmst_pkg.sv
// ----------------------------------------------------------------------------
// srmst_pkg
// Shared constants, types and per-channel tables of the season tracker.
// ----------------------------------------------------------------------------
package srmst_pkg;

  localparam int SEASON_COUNT = 4;
  localparam int SEASON_BITS  = (SEASON_COUNT > 1) ? $clog2(SEASON_COUNT) : 1;
  localparam int FRAC_BITS    = 4;
  localparam int CH_COUNT     = 4;

  localparam logic [15:0] ALPHA_RESET = 16'd6554;

  localparam logic [1:0] CH_TEMP     = 2'd0;
  localparam logic [1:0] CH_HUMIDITY = 2'd1;
  localparam logic [1:0] CH_GAS      = 2'd2;
  localparam logic [1:0] CH_DUST     = 2'd3;

  typedef logic [13:0] mean_t;
  typedef logic [15:0] dev_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  function automatic logic [17:0] mean_top(input logic [1:0] ch);
    unique case (ch)
      CH_TEMP:     mean_top = 18'(100  << FRAC_BITS);
      CH_HUMIDITY: mean_top = 18'(100  << FRAC_BITS);
      CH_GAS:      mean_top = 18'(1000 << FRAC_BITS);
      default:     mean_top = 18'(500  << FRAC_BITS);
    endcase
  endfunction

  function automatic logic [17:0] dev_floor(input logic [1:0] ch);
    unique case (ch)
      CH_TEMP:     dev_floor = 18'(5  << FRAC_BITS);
      CH_HUMIDITY: dev_floor = 18'(5  << FRAC_BITS);
      CH_GAS:      dev_floor = 18'(50 << FRAC_BITS);
      default:     dev_floor = 18'(25 << FRAC_BITS);
    endcase
  endfunction

  function automatic mean_t mean_reset(input logic [1:0] ch);
    unique case (ch)
      CH_TEMP:     mean_reset = 14'd400;
      CH_HUMIDITY: mean_reset = 14'd800;
      default:     mean_reset = 14'd0;
    endcase
  endfunction

  function automatic dev_t dev_reset(input logic [1:0] ch);
    unique case (ch)
      CH_TEMP:     dev_reset = 16'd80;
      CH_HUMIDITY: dev_reset = 16'd160;
      default:     dev_reset = 16'd16;
    endcase
  endfunction

endpackage

// File: rtl/srmst_if.sv
// ----------------------------------------------------------------------------
// srmst interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srmst_sample_if;
  logic              valid;
  logic              ready;
  logic [1:0]        season;
  logic signed [15:0] temp_sample;
  logic signed [15:0] humidity_sample;
  logic signed [15:0] gas_sample;
  logic signed [15:0] dust_sample;
  modport source (output valid, season, temp_sample, humidity_sample, gas_sample,
                  dust_sample, input ready);
  modport sink (input valid, season, temp_sample, humidity_sample, gas_sample,
                dust_sample, output ready);
endinterface

interface srmst_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  season_out;
  logic [15:0] count_out;
  logic [10:0] temp_mean_out;
  logic [10:0] humidity_mean_out;
  logic [13:0] gas_mean_out;
  logic [12:0] dust_mean_out;
  logic [15:0] temp_dev_out;
  logic [15:0] humidity_dev_out;
  logic [15:0] gas_dev_out;
  logic [15:0] dust_dev_out;
  modport source (output valid, season_out, count_out, temp_mean_out, humidity_mean_out,
                  gas_mean_out, dust_mean_out, temp_dev_out, humidity_dev_out,
                  gas_dev_out, dust_dev_out, input ready);
  modport sink (input valid, season_out, count_out, temp_mean_out, humidity_mean_out,
                gas_mean_out, dust_mean_out, temp_dev_out, humidity_dev_out,
                gas_dev_out, dust_dev_out, output ready);
endinterface

interface srmst_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/seasonal_running_mean_std_tracker.sv
// ----------------------------------------------------------------------------
// seasonal_running_mean_std_tracker
// Four channel lanes in lockstep update one season; results merged here.
// ----------------------------------------------------------------------------
// From request to result register: four multiply/add steps, a square root
// (load, 18 bit-pair steps, finish), then the load of the result register.
// No new request is taken while busy; one is taken while the previous result
// waits in the output register, lanes hold when it is full.
// Reset (rst, synchronous): alpha 6554, counts zero, means and deviations
// to their start values at once; no clearing pass.
module seasonal_running_mean_std_tracker
  import srmst_pkg::*;
(
  input logic              clk,
  input logic              rst,
  srmst_sample_if.sink     smp,
  srmst_result_if.source   res,
  srmst_cfg_if.sink        cfg
);

  logic [15:0]            alpha;
  logic [15:0]            cnt [SEASON_COUNT];
  logic [15:0]            cnt_r;
  logic [SEASON_BITS-1:0] sea_r;
  logic                   busy;
  logic                   accept;
  logic                   load;
  logic [SEASON_BITS-1:0] sea_in;
  logic                   all_done;

  lane_stat_t      stat [CH_COUNT];
  mean_t           mean [CH_COUNT];
  dev_t            dev  [CH_COUNT];
  logic signed [15:0] samp [CH_COUNT];

  assign sea_in  = smp.season[SEASON_BITS-1:0];
  assign smp.ready = !busy;
  assign accept  = smp.valid && smp.ready;
  assign cfg.ready = 1'b1;

  assign samp[0] = smp.temp_sample;
  assign samp[1] = smp.humidity_sample;
  assign samp[2] = smp.gas_sample;
  assign samp[3] = smp.dust_sample;

  for (genvar g = 0; g < CH_COUNT; g++) begin : g_lane
    srmst_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ch     (2'(g)),
      .start  (accept),
      .season (sea_in),
      .sample (samp[g]),
      .alpha  (alpha),
      .stat   (stat[g]),
      .mean   (mean[g]),
      .dev    (dev[g])
    );
  end

  assign all_done = stat[0].done && stat[1].done && stat[2].done && stat[3].done;
  assign load     = busy && all_done && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      busy      <= 1'b0;
      res.valid <= 1'b0;
      for (int i = 0; i < SEASON_COUNT; i++) cnt[i] <= '0;
    end else begin
      if (cfg.valid) alpha <= cfg.data;
      if (accept) begin
        busy        <= 1'b1;
        sea_r       <= sea_in;
        cnt_r       <= cnt[sea_in] + 16'd1;
        cnt[sea_in] <= cnt[sea_in] + 16'd1;
      end
      if (load) begin
        busy                  <= 1'b0;
        res.valid             <= 1'b1;
        res.season_out        <= 2'(sea_r);
        res.count_out         <= cnt_r;
        res.temp_mean_out     <= mean[0][10:0];
        res.humidity_mean_out <= mean[1][10:0];
        res.gas_mean_out      <= mean[2];
        res.dust_mean_out     <= mean[3][12:0];
        res.temp_dev_out      <= dev[0];
        res.humidity_dev_out  <= dev[1];
        res.gas_dev_out       <= dev[2];
        res.dust_dev_out      <= dev[3];
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/srmst_lane.sv
// ----------------------------------------------------------------------------
// srmst_lane
// One channel: per-season EMA mean, EMA variance and bit-pair square root.
// ----------------------------------------------------------------------------
module srmst_lane
  import srmst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             ch,
  input  logic                   start,
  input  logic [SEASON_BITS-1:0] season,
  input  logic signed [15:0]     sample,
  input  logic [15:0]            alpha,
  output lane_stat_t             stat,
  output mean_t                  mean,
  output dev_t                   dev
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_VAR  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  mean_t mean_mem [SEASON_COUNT];
  dev_t  dev_mem  [SEASON_COUNT];

  logic [2:0]             state;
  logic [SEASON_BITS-1:0] idx;
  logic signed [15:0]     smp;
  logic [15:0]            a;
  logic [16:0]            keep;
  logic [30:0]            p1;
  logic signed [33:0]     p2;
  logic [31:0]            dev2;
  logic [16:0]            dabs;
  logic [33:0]            dd;
  logic [48:0]            q1;
  logic [34:0]            rem;
  logic [34:0]            res;
  logic [34:0]            bit_r;
  logic [4:0]             iter;

  logic signed [35:0] t;
  logic signed [35:0] t_rnd;
  logic [17:0]        m_calc;
  logic signed [18:0] d_s;
  logic [50:0]        vsum;
  logic [35:0]        trial;
  logic [34:0]        r_fl;

  assign keep = 17'h10000 - {1'b0, a};

  always_comb begin
    t     = 36'(signed'({5'd0, p1})) + 36'(p2);
    t_rnd = t + 36'sd32768;
    if (t < 0) begin
      m_calc = '0;
    end else if (t_rnd[35:16] > 20'(mean_top(ch))) begin
      m_calc = mean_top(ch);
    end else begin
      m_calc = t_rnd[33:16];
    end
  end

  assign d_s   = 19'(smp) - signed'({5'd0, mean});
  assign vsum  = 51'(q1) + 51'({16'd0, a} * {16'd0, dd}) + 51'd32768;
  assign trial = {1'b0, res} + {1'b0, bit_r};

  always_comb begin
    r_fl = res;
    if (r_fl < 35'(dev_floor(ch))) r_fl = 35'(dev_floor(ch));
    if (r_fl > 35'd65535) r_fl = 35'd65535;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      a     <= '0;
      for (int i = 0; i < SEASON_COUNT; i++) begin
        mean_mem[i] <= mean_reset(ch);
        dev_mem[i]  <= dev_reset(ch);
      end
    end else begin
      unique case (state)
        ST_IDLE, ST_DONE: begin
          if (start) begin
            idx   <= season;
            smp   <= sample;
            a     <= alpha;
            mean  <= mean_mem[season];
            dev   <= dev_mem[season];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          p1    <= 31'({14'd0, keep} * {17'd0, mean});
          p2    <= 34'(signed'({18'd0, a}) * 34'(smp));
          dev2  <= dev * dev;
          state <= ST_ADD;
        end
        ST_ADD: begin
          mean  <= m_calc[13:0];
          q1    <= 49'({32'd0, keep} * {17'd0, dev2});
          state <= ST_VAR;
        end
        ST_VAR: begin
          dabs  <= d_s[18] ? 17'(-d_s) : d_s[16:0];
          state <= ST_SUM;
        end
        ST_SUM: begin
          dd    <= {17'd0, dabs} * {17'd0, dabs};
          state <= ST_ROOT;
          iter  <= '0;
          res   <= '0;
          bit_r <= 35'd1 << 34;
        end
        ST_ROOT: begin
          iter <= iter + 5'd1;
          if (iter == 5'd0) begin
            rem <= vsum[50:16];
          end else if (iter <= 5'd18) begin
            if ({1'b0, rem} >= trial) begin
              rem <= rem - trial[34:0];
              res <= (res >> 1) + bit_r;
            end else begin
              res <= res >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            // all 18 bit pairs resolved
            state         <= ST_DONE;
            dev           <= r_fl[15:0];
            mean_mem[idx] <= mean;
            dev_mem[idx]  <= r_fl[15:0];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != ST_IDLE) && (state != ST_DONE);
  assign stat.done = (state == ST_DONE);

endmodule

// File: rtl/srmst_checker.sv
// ----------------------------------------------------------------------------
// srmst_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module srmst_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] count_out,
  input logic [10:0] temp_mean_out,
  input logic [15:0] temp_dev_out,
  input logic [15:0] gas_dev_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_out))
    else $error("result dropped under stall");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_dev_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temp_dev_out >= 16'd80 && gas_dev_out >= 16'd800)
    else $error("deviation below floor");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temp_mean_out <= 11'd1600)
    else $error("mean out of range");

endmodule

bind seasonal_running_mean_std_tracker srmst_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (smp.valid),
  .in_ready      (smp.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .count_out     (res.count_out),
  .temp_mean_out (res.temp_mean_out),
  .temp_dev_out  (res.temp_dev_out),
  .gas_dev_out   (res.gas_dev_out)
);

// File: tb/sv/srmst_tb_if.sv
// ----------------------------------------------------------------------------
// srmst test channels
// Bench-side copies are not needed; the RTL interfaces are used directly.
// This file holds the request and result records used by the bench.
// ----------------------------------------------------------------------------
package srmst_tb_pkg;

  typedef struct packed {
    logic [1:0]         season;
    logic signed [15:0] temp;
    logic signed [15:0] hum;
    logic signed [15:0] gas;
    logic signed [15:0] dust;
  } sample_req_t;

  typedef struct packed {
    logic [1:0]  season;
    logic [15:0] count;
    logic [10:0] temp_avg;
    logic [10:0] hum_avg;
    logic [13:0] gas_avg;
    logic [12:0] dust_avg;
    logic [15:0] temp_dev;
    logic [15:0] hum_dev;
    logic [15:0] gas_dev;
    logic [15:0] dust_dev;
  } season_stats_t;

endpackage

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sensor requests and alpha writes into the season tracker, predicts
// each season's moving means and deviations, and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import srmst_pkg::*;
  import srmst_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 25;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srmst_sample_if smp ();
  srmst_result_if res ();
  srmst_cfg_if    cfg ();

  seasonal_running_mean_std_tracker dut (
    .clk(clk), .rst(rst), .smp(smp.sink), .res(res.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] alpha_q;
  logic [15:0] cnt_q  [4];
  logic [13:0] mean_q [4][4];
  logic [15:0] dev_q  [4][4];

  season_stats_t stats_q[$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int checked = 0;
  int taken = 0;
  int rx_seen = 0;
  int rx_wait = 0;
  int hold_off = 0;
  bit rx_random = 1'b1;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic track_channel(input int s, input logic [1:0] ch,
                               input logic signed [15:0] x);
    longint a, keep, t, m, d;
    logic [63:0] v, r;
    a = alpha_q;
    keep = 65536 - a;
    t = keep * longint'(mean_q[s][ch]) + a * longint'(x);
    m = (t < 0) ? 0 : ((t + 32768) >>> 16);
    if (m > longint'(mean_top(ch))) m = mean_top(ch);
    mean_q[s][ch] = 14'(m);
    d = longint'(x) - m;
    if (d < 0) d = -d;
    v = (64'(keep) * dev_q[s][ch] * dev_q[s][ch] + 64'(a) * 64'(d) * 64'(d)
         + 64'd32768) >> 16;
    r = root64(v);
    if (r < dev_floor(ch)) r = dev_floor(ch);
    if (r > 64'hFFFF) r = 64'hFFFF;
    dev_q[s][ch] = 16'(r);
  endtask

  function automatic void tracker_reset();
    alpha_q = ALPHA_RESET;
    for (int s = 0; s < 4; s++) begin
      cnt_q[s] = '0;
      for (int c = 0; c < 4; c++) begin
        mean_q[s][c] = mean_reset(2'(c));
        dev_q[s][c]  = dev_reset(2'(c));
      end
    end
  endfunction

  task automatic predict_stats(input sample_req_t q, output season_stats_t o);
    int s;
    s = q.season % SEASON_COUNT;
    cnt_q[s] = cnt_q[s] + 16'd1;
    track_channel(s, CH_TEMP, q.temp);
    track_channel(s, CH_HUMIDITY, q.hum);
    track_channel(s, CH_GAS, q.gas);
    track_channel(s, CH_DUST, q.dust);
    o.season    = 2'(s);
    o.count     = cnt_q[s];
    o.temp_avg  = mean_q[s][CH_TEMP][10:0];
    o.hum_avg   = mean_q[s][CH_HUMIDITY][10:0];
    o.gas_avg   = mean_q[s][CH_GAS];
    o.dust_avg  = mean_q[s][CH_DUST][12:0];
    o.temp_dev  = dev_q[s][CH_TEMP];
    o.hum_dev   = dev_q[s][CH_HUMIDITY];
    o.gas_dev   = dev_q[s][CH_GAS];
    o.dust_dev  = dev_q[s][CH_DUST];
  endtask

  task automatic wait_falls(input int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_sample(input sample_req_t q);
    season_stats_t e;
    smp.season = q.season;
    smp.temp_sample = q.temp;
    smp.humidity_sample = q.hum;
    smp.gas_sample = q.gas;
    smp.dust_sample = q.dust;
    smp.valid = 1'b1;
    do @(posedge clk); while (!smp.ready);
    predict_stats(q, e);
    stats_q.push_back(e);
    accepted++;
    @(negedge clk);
    smp.valid = 1'b0;
  endtask

  task automatic write_alpha(input logic [15:0] val);
    while (stats_q.size() != 0) @(negedge clk);
    wait_falls(LATENCY + 4);
    cfg.valid <= 1'b1;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    alpha_q = val;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic sample_req_t rand_sample(input bit plausible);
    sample_req_t q;
    q.season = 2'($urandom_range(0, 3));
    if (plausible) begin
      q.temp = 16'($urandom_range(0, 1800)) - 16'sd100;
      q.hum  = 16'($urandom_range(0, 1700));
      q.gas  = 16'($urandom_range(0, 17000));
      q.dust = 16'($urandom_range(0, 9000));
    end else begin
      q = {q.season, 64'({$urandom, $urandom})};
    end
    return q;
  endfunction

  // directed rows; only the first row after reset has its result typed in
  typedef struct {
    logic [16:0]   alpha_set; // bit 16 marks an alpha write before the row
    sample_req_t   q;
    bit            typed;
    season_stats_t want;
  } step_row_t;

  step_row_t rows[$];

  function automatic void add_row(input logic [16:0] al, input logic [1:0] s,
    input logic [15:0] t, h, g, d);
    step_row_t r;
    r.alpha_set = al;
    r.q = '{s, t, h, g, d};
    r.typed = 1'b0;
    r.want = '0;
    rows.push_back(r);
  endfunction

  // sink side: a fresh random wait is drawn after each result
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      res.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!rx_random) begin
      res.ready <= 1'b1;
    end else begin
      if (rx_seen != taken) begin
        rx_seen = taken;
        rx_wait = $urandom_range(0, 13);
      end
      if (rx_wait > 0) begin
        res.ready <= 1'b0;
        rx_wait = rx_wait - 1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    season_stats_t got, e;
    if (!rst && res.valid && res.ready) begin
      taken++;
      got = '{res.season_out, res.count_out, res.temp_mean_out, res.humidity_mean_out,
              res.gas_mean_out, res.dust_mean_out, res.temp_dev_out,
              res.humidity_dev_out, res.gas_dev_out, res.dust_dev_out};
      if (stats_q.size() == 0) begin
        $display("%0t: result with none expected: %p", $realtime, got);
        errors++;
      end else begin
        e = stats_q.pop_front();
        checked++;
        if (got !== e) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, e, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    step_row_t r;
    season_stats_t e;
    int n;
    logic [15:0] al;
    smp.valid = 1'b0;
    smp.season = '0;
    smp.temp_sample = '0;
    smp.humidity_sample = '0;
    smp.gas_sample = '0;
    smp.dust_sample = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    tracker_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first request after reset at reset alpha: sample equal to start means
    r.alpha_set = '0;
    r.q = '{2'd0, 16'sd400, 16'sd800, 16'sd0, 16'sd0};
    r.typed = 1'b1;
    r.want = '{2'd0, 16'd1, 11'd400, 11'd800, 14'd0, 13'd0, 16'd80, 16'd151,
               16'd800, 16'd400};
    rows.push_back(r);
    add_row(17'h0, 2'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_row(17'h0, 2'd2, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_row(17'h0, 2'd3, 16'hFFFF, 16'h0001, 16'd16000, 16'd8000);
    add_row(17'h1FFFF, 2'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_row(17'h0, 2'd1, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_row(17'h0, 2'd2, 16'd1600, 16'd1600, 16'd16000, 16'd8000);
    add_row(17'h10000, 2'd0, 16'h1234, 16'h8000, 16'h7FFF, 16'h5555);
    add_row(17'h0, 2'd3, 16'd0, 16'd0, 16'd0, 16'd0);
    add_row(17'h10001, 2'd3, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    add_row(17'h18000, 2'd2, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h2AAA);
    add_row(17'h0, 2'd0, 16'd50, 16'd900, 16'd300, 16'd100);
    add_row(17'h0, 2'd0, 16'd50, 16'd900, 16'd300, 16'd100);
    add_row(17'h1199A, 2'd1, 16'd200, 16'd200, 16'd200, 16'd200);

    foreach (rows[i]) begin
      if (rows[i].alpha_set[16]) write_alpha(rows[i].alpha_set[15:0]);
      send_sample(rows[i].q);
      if (rows[i].typed) stats_q[stats_q.size() - 1] = rows[i].want;
    end

    // back-to-back requests on season 3, ready held high
    rx_random = 1'b0;
    for (int i = 0; i < 40; i++) begin
      send_sample('{2'd3, 16'sd10, 16'sd20, 16'sd30, 16'sd40});
    end
    rx_random = 1'b1;

    for (int i = 0; i < 1300; i++) begin
      if (i % 300 == 0) begin
        // phase change: alpha from extremes and random values
        unique case ((i / 300) % 5)
          0: al = 16'h0000;
          1: al = 16'hFFFF;
          2: al = 16'h0001;
          default: al = 16'($urandom);
        endcase
        write_alpha(al);
      end
      if (i == 500) hold_off = 300;      // receiver stalls, input backs up
      if (i == 900) while (stats_q.size() != 0) @(negedge clk);
      wait_falls($urandom_range(0, 13));
      send_sample(rand_sample($urandom_range(0, 9) < 8));
    end

    n = 0;
    while (stats_q.size() != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    wait_falls(LATENCY * 2);
    $display("%0d requests accepted, %0d results checked", accepted, checked);
    $display("covered alpha extremes, back-to-back requests and a long result stall");
    if (errors == 0 && stats_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, stats_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
